// File: rtl/oolt_pkg.sv
// Shared types and constants for the ordered open list table.
package oolt_pkg;

   // Default sizing
   localparam int CAPACITY_DEF    = 256;
   localparam int HANDLE_BITS_DEF = 16;
   localparam int COST_BITS_DEF   = 16;

   // Fixed port field widths
   localparam int REQ_TYPE_W = 3;
   localparam int SLOT_W     = 8;
   localparam int HANDLE_W   = 16;
   localparam int COST_W     = 16;
   localparam int STATUS_W   = 2;
   localparam int FILL_W     = 9;

   // Request codes
   typedef enum logic [REQ_TYPE_W-1:0] {
      OP_APPEND  = 3'd0,
      OP_READ    = 3'd1,
      OP_DEL_AT  = 3'd2,
      OP_DEL_KEY = 3'd3,
      OP_FIND    = 3'd4,
      OP_LOWEST  = 3'd5
   } op_type;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_MISS  = 2'd1,
      STAT_FULL  = 2'd2,
      STAT_EMPTY = 2'd3
   } status_type;

endpackage

// File: rtl/oolt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module oolt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/ordered_open_list_table_core.sv
// Ordered open list table: entries of handle and cost in one RAM, walked by a sequencer.
// Append writes its entry straight from idle; read reads its one slot; find, delete by
// handle, delete at index and lowest walk the entries, one RAM read per entry walked.
// Throughput: one request at a time; the next is taken once the previous result
// is in the output register, which holds it until the transfer completes.
// Reset: synchronous; the fill count clears at once, entry storage is not cleared.
module ordered_open_list_table_core #(
   parameter int CAPACITY    = oolt_pkg::CAPACITY_DEF,
   parameter int HANDLE_BITS = oolt_pkg::HANDLE_BITS_DEF,
   parameter int COST_BITS   = oolt_pkg::COST_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [oolt_pkg::REQ_TYPE_W-1:0] req_type,
   input  logic [oolt_pkg::SLOT_W-1:0]     req_slot,
   input  logic [oolt_pkg::HANDLE_W-1:0]   req_handle,
   input  logic [oolt_pkg::COST_W-1:0]     req_cost,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [oolt_pkg::STATUS_W-1:0]   rsp_status,
   output logic [oolt_pkg::SLOT_W-1:0]     rsp_slot_out,
   output logic [oolt_pkg::HANDLE_W-1:0]   rsp_handle_out,
   output logic [oolt_pkg::COST_W-1:0]     rsp_cost_out,
   output logic [oolt_pkg::FILL_W-1:0]     rsp_fill
);

   import oolt_pkg::*;

   localparam int IDX_W   = $clog2(CAPACITY);
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int CMP_W   = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
   localparam int ENTRY_W = HANDLE_BITS + COST_BITS;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_SHIFT  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   // control state
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // working registers
   op_type                 op_ff, op_in;
   logic [IDX_W-1:0]       cur_ff, cur_in;
   logic [HANDLE_BITS-1:0] key_ff, key_in;
   status_type             res_status_ff, res_status_in;
   logic [IDX_W-1:0]       res_slot_ff, res_slot_in;
   logic [HANDLE_BITS-1:0] res_handle_ff, res_handle_in;
   logic [COST_BITS-1:0]   res_cost_ff, res_cost_in;

   // output register
   status_type             out_status_ff;
   logic [IDX_W-1:0]       out_slot_ff;
   logic [HANDLE_BITS-1:0] out_handle_ff;
   logic [COST_BITS-1:0]   out_cost_ff;
   logic [CNT_W-1:0]       out_fill_ff;

   // RAM port
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [ENTRY_W-1:0]     wr_data;
   logic [IDX_W-1:0]       rd_addr;
   logic [ENTRY_W-1:0]     rd_data;
   logic [HANDLE_BITS-1:0] rd_handle;
   logic [COST_BITS-1:0]   rd_cost;

   // decode helpers
   op_type                 req_op;
   logic [HANDLE_BITS-1:0] in_handle;
   logic [COST_BITS-1:0]   in_cost;
   logic                   slot_ok;
   logic [CNT_W-1:0]       nxt_cnt;
   logic                   more;
   logic [IDX_W-1:0]       nxt_idx;
   logic                   out_load;

   oolt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_handle = rd_data[COST_BITS +: HANDLE_BITS];
   assign rd_cost   = rd_data[0 +: COST_BITS];

   assign req_op    = op_type'(req_type);
   assign in_handle = HANDLE_BITS'(req_handle);
   assign in_cost   = COST_BITS'(req_cost);
   assign slot_ok   = CMP_W'(req_slot) < CMP_W'(count_ff);

   // next entry of the walk and whether it is still held
   assign nxt_cnt = CNT_W'(cur_ff) + CNT_W'(1);
   assign more    = nxt_cnt < count_ff;
   assign nxt_idx = IDX_W'(nxt_cnt);

   assign req_stall = (state_ff != ST_IDLE);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      op_in         = op_ff;
      cur_in        = cur_ff;
      key_in        = key_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_handle_in = res_handle_ff;
      res_cost_in   = res_cost_ff;
      wr_en         = 1'b0;
      wr_addr       = cur_ff - IDX_W'(1);
      wr_data       = rd_data;
      rd_addr       = cur_ff;
      out_load      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in         = req_op;
               key_in        = in_handle;
               res_status_in = STAT_MISS;
               res_slot_in   = '0;
               res_handle_in = '0;
               res_cost_in   = '0;
               state_in      = ST_FINISH;
               unique case (req_op)
                  OP_APPEND: begin
                     if (count_ff < CNT_W'(CAPACITY)) begin
                        wr_en         = 1'b1;
                        wr_addr       = IDX_W'(count_ff);
                        wr_data       = {in_handle, in_cost};
                        res_status_in = STAT_OK;
                        res_slot_in   = IDX_W'(count_ff);
                        res_handle_in = in_handle;
                        res_cost_in   = in_cost;
                        count_in      = count_ff + CNT_W'(1);
                     end else begin
                        res_status_in = STAT_FULL;
                     end
                  end
                  OP_READ, OP_DEL_AT: begin
                     if (slot_ok) begin
                        rd_addr  = IDX_W'(req_slot);
                        cur_in   = IDX_W'(req_slot);
                        state_in = ST_SCAN;
                     end
                  end
                  OP_DEL_KEY, OP_FIND: begin
                     if (count_ff != '0) begin
                        rd_addr  = '0;
                        cur_in   = '0;
                        state_in = ST_SCAN;
                     end
                  end
                  OP_LOWEST: begin
                     if (count_ff == '0) begin
                        res_status_in = STAT_EMPTY;
                     end else begin
                        res_status_in = STAT_OK;
                        rd_addr       = '0;
                        cur_in        = '0;
                        state_in      = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // entry at cur_ff is on the RAM output
         ST_SCAN: begin
            unique case (op_ff)
               OP_READ, OP_DEL_AT, OP_DEL_KEY, OP_FIND: begin
                  if (op_ff == OP_READ || op_ff == OP_DEL_AT || rd_handle == key_ff) begin
                     res_status_in = STAT_OK;
                     res_slot_in   = cur_ff;
                     res_handle_in = rd_handle;
                     res_cost_in   = rd_cost;
                     state_in      = ST_FINISH;
                     if (op_ff == OP_DEL_AT || op_ff == OP_DEL_KEY) begin
                        if (more) begin
                           rd_addr  = nxt_idx;
                           cur_in   = nxt_idx;
                           state_in = ST_SHIFT;
                        end else begin
                           count_in = count_ff - CNT_W'(1);
                        end
                     end
                  end else if (more) begin
                     rd_addr = nxt_idx;
                     cur_in  = nxt_idx;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end
               OP_LOWEST: begin
                  // strict compare keeps the earliest of equal costs
                  if (cur_ff == '0 || rd_cost < res_cost_ff) begin
                     res_slot_in   = cur_ff;
                     res_handle_in = rd_handle;
                     res_cost_in   = rd_cost;
                  end
                  if (more) begin
                     rd_addr = nxt_idx;
                     cur_in  = nxt_idx;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end

         // move entry cur_ff down by one, read the next
         ST_SHIFT: begin
            wr_en = 1'b1;
            if (more) begin
               rd_addr = nxt_idx;
               cur_in  = nxt_idx;
            end else begin
               count_in = count_ff - CNT_W'(1);
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load | (rsp_valid_ff & rsp_stall);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      cur_ff        <= cur_in;
      key_ff        <= key_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_handle_ff <= res_handle_in;
      res_cost_ff   <= res_cost_in;
      if (out_load) begin
         out_status_ff <= res_status_ff;
         out_slot_ff   <= res_slot_ff;
         out_handle_ff <= res_handle_ff;
         out_cost_ff   <= res_cost_ff;
         out_fill_ff   <= count_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_slot_out   = SLOT_W'(out_slot_ff);
   assign rsp_handle_out = HANDLE_W'(out_handle_ff);
   assign rsp_cost_out   = COST_W'(out_cost_ff);
   assign rsp_fill       = FILL_W'(out_fill_ff);

endmodule

// File: tb/tb.sv
// Self-checking testbench for the ordered open list table core.
`timescale 1ns / 100ps

module tb;
   import oolt_pkg::*;

   // Request codes the block must refuse
   localparam logic [REQ_TYPE_W-1:0] OP_RSVD6 = 3'd6;
   localparam logic [REQ_TYPE_W-1:0] OP_RSVD7 = 3'd7;

   localparam int unsigned RANDOM_ITEMS = 1000;
   localparam int unsigned DRAIN_CYCLES = 300;
   localparam int unsigned TIMEOUT_NS   = 12_000_000;
   localparam int unsigned REPORT_MAX   = 10;

   typedef struct {
      status_type            status;
      logic [SLOT_W-1:0]     slot;
      logic [HANDLE_W-1:0]   handle;
      logic [COST_W-1:0]     cost;
      logic [FILL_W-1:0]     fill;
   } list_response_type;

   // Mirror of the table: predicts each response and checks the block against it
   class open_list_mirror;
      logic [HANDLE_W-1:0] handle_tbl [CAPACITY_DEF];
      logic [COST_W-1:0]   cost_tbl [CAPACITY_DEF];
      int unsigned         count;
      int unsigned         last_slot;
      int unsigned         failures;
      list_response_type   expected_responses [$];

      function new();
         count     = 0;
         last_slot = 0;
         failures  = 0;
      endfunction

      // Remove one entry, later entries move down by one
      function void drop_entry(int unsigned idx);
         for (int unsigned i = idx; i + 1 < count; i++) begin
            handle_tbl[i] = handle_tbl[i + 1];
            cost_tbl[i]   = cost_tbl[i + 1];
         end
         count--;
      endfunction

      function void apply_request(logic [REQ_TYPE_W-1:0] op, logic [SLOT_W-1:0] slot,
                                  logic [HANDLE_W-1:0] handle, logic [COST_W-1:0] cost);
         list_response_type rsp;
         int unsigned       pick;
         bit                hit;
         rsp.status = STAT_MISS;
         rsp.slot   = '0;
         rsp.handle = '0;
         rsp.cost   = '0;
         pick       = 0;
         hit        = 1'b0;
         case (op)
            OP_APPEND: begin
               if (count >= CAPACITY_DEF) begin
                  rsp.status = STAT_FULL;
               end else begin
                  handle_tbl[count] = handle;
                  cost_tbl[count]   = cost;
                  pick              = count;
                  hit               = 1'b1;
                  count++;
               end
            end
            OP_READ, OP_DEL_AT: begin
               if (slot < count) begin
                  hit  = 1'b1;
                  pick = slot;
               end
            end
            OP_DEL_KEY, OP_FIND: begin
               // first match wins
               for (int unsigned i = 0; i < count && !hit; i++) begin
                  if (handle_tbl[i] == handle) begin
                     hit  = 1'b1;
                     pick = i;
                  end
               end
            end
            OP_LOWEST: begin
               if (count == 0) begin
                  rsp.status = STAT_EMPTY;
               end else begin
                  // strict compare keeps the smallest index on a tie
                  hit = 1'b1;
                  for (int unsigned i = 1; i < count; i++) begin
                     if (cost_tbl[i] < cost_tbl[pick]) pick = i;
                  end
               end
            end
            default: ;
         endcase
         if (hit) begin
            rsp.status = STAT_OK;
            rsp.slot   = pick[SLOT_W-1:0];
            rsp.handle = handle_tbl[pick];
            rsp.cost   = cost_tbl[pick];
            if (op == OP_DEL_AT || op == OP_DEL_KEY) drop_entry(pick);
         end
         rsp.fill  = count[FILL_W-1:0];
         last_slot = pick;
         expected_responses.push_back(rsp);
      endfunction

      function void check_response(list_response_type got);
         list_response_type want;
         string             diffs;
         if (expected_responses.size() == 0) begin
            failures++;
            if (failures <= REPORT_MAX)
               $display("%0t: unexpected response status=%0d slot=%0d handle=%h cost=%h fill=%0d",
                        $time, got.status, got.slot, got.handle, got.cost, got.fill);
            return;
         end
         want  = expected_responses.pop_front();
         diffs = "";
         if (got.status !== want.status) diffs = {diffs, " status"};
         if (got.slot   !== want.slot)   diffs = {diffs, " slot"};
         if (got.handle !== want.handle) diffs = {diffs, " handle"};
         if (got.cost   !== want.cost)   diffs = {diffs, " cost"};
         if (got.fill   !== want.fill)   diffs = {diffs, " fill"};
         if (diffs != "") begin
            failures++;
            if (failures <= REPORT_MAX) begin
               $display("%0t: mismatch in%s", $time, diffs);
               $display("   expected status=%0d slot=%0d handle=%h cost=%h fill=%0d",
                        want.status, want.slot, want.handle, want.cost, want.fill);
               $display("   actual   status=%0d slot=%0d handle=%h cost=%h fill=%0d",
                        got.status, got.slot, got.handle, got.cost, got.fill);
            end
         end
      endfunction

      function int unsigned pending();
         return expected_responses.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [SLOT_W-1:0]     req_slot;
   logic [HANDLE_W-1:0]   req_handle;
   logic [COST_W-1:0]     req_cost;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [STATUS_W-1:0]   rsp_status;
   logic [SLOT_W-1:0]     rsp_slot_out;
   logic [HANDLE_W-1:0]   rsp_handle_out;
   logic [COST_W-1:0]     rsp_cost_out;
   logic [FILL_W-1:0]     rsp_fill;

   open_list_mirror mirror = new();
   int unsigned     burst_left;
   int unsigned     random_sent;

   ordered_open_list_table_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_slot       (req_slot),
      .req_handle     (req_handle),
      .req_cost       (req_cost),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_slot_out   (rsp_slot_out),
      .rsp_handle_out (rsp_handle_out),
      .rsp_cost_out   (rsp_cost_out),
      .rsp_fill       (rsp_fill)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Called at a falling edge; returns at a falling edge after the transfer
   task automatic send_request(logic [REQ_TYPE_W-1:0] op, logic [SLOT_W-1:0] slot,
                               logic [HANDLE_W-1:0] handle, logic [COST_W-1:0] cost);
      req_valid  = 1'b1;
      req_type   = op;
      req_slot   = slot;
      req_handle = handle;
      req_cost   = cost;
      do @(posedge clock); while (req_stall !== 1'b0);
      mirror.apply_request(op, slot, handle, cost);
      @(negedge clock);
      // end of burst: idle for a while
      if (burst_left == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = $urandom_range(0, 40);
      end else begin
         burst_left--;
      end
   endtask

   // About half the handles come from the table, so finds and deletes hit
   function automatic logic [HANDLE_W-1:0] pick_handle();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 5 && mirror.count > 0)
         return mirror.handle_tbl[$urandom_range(0, mirror.count - 1)];
      if (r < 8) return HANDLE_W'($urandom_range(0, 15));
      if (r == 8) return $urandom_range(0, 1) ? '1 : '0;
      return HANDLE_W'($urandom_range(0, 65535));
   endfunction

   // Small costs give plenty of ties for the lowest
   function automatic logic [COST_W-1:0] pick_cost();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 4) return COST_W'($urandom_range(0, 7));
      if (r == 4) return $urandom_range(0, 1) ? '1 : '0;
      return COST_W'($urandom_range(0, 65535));
   endfunction

   function automatic logic [SLOT_W-1:0] pick_slot();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 8 && mirror.count > 0) return SLOT_W'($urandom_range(0, mirror.count - 1));
      if (r == 8) return mirror.count[SLOT_W-1:0];
      return SLOT_W'($urandom_range(0, 255));
   endfunction

   // One random request, steered towards a target fill level
   task automatic send_random(int unsigned goal);
      int unsigned           r;
      logic [REQ_TYPE_W-1:0] op;
      r = $urandom_range(0, 99);
      if (r < 3) begin
         send_request(r[0] ? OP_RSVD7 : OP_RSVD6, SLOT_W'($urandom_range(0, 255)),
                      HANDLE_W'($urandom_range(0, 65535)), COST_W'($urandom_range(0, 65535)));
         return;
      end
      if (mirror.count < goal) begin
         if (r < 75)      op = OP_APPEND;
         else if (r < 83) op = OP_FIND;
         else if (r < 89) op = OP_READ;
         else if (r < 94) op = OP_LOWEST;
         else if (r < 97) op = OP_DEL_KEY;
         else             op = OP_DEL_AT;
      end else if (mirror.count > goal) begin
         if (r < 20)      op = OP_APPEND;
         else if (r < 35) op = OP_FIND;
         else if (r < 45) op = OP_READ;
         else if (r < 70) op = OP_LOWEST;
         else if (r < 85) op = OP_DEL_KEY;
         else             op = OP_DEL_AT;
      end else begin
         case (r % 6)
            0:       op = OP_APPEND;
            1:       op = OP_READ;
            2:       op = OP_DEL_AT;
            3:       op = OP_DEL_KEY;
            4:       op = OP_FIND;
            default: op = OP_LOWEST;
         endcase
      end
      send_request(op, pick_slot(), pick_handle(), pick_cost());
      random_sent++;
      // open list usage: take the lowest, then remove it
      if (op == OP_LOWEST && mirror.count > goal) begin
         send_request(OP_DEL_AT, mirror.last_slot[SLOT_W-1:0], pick_handle(), pick_cost());
         random_sent++;
      end
   endtask

   // Receiver back-pressure: stretches of no stall, random stall and long stalls
   initial begin : rsp_backpressure
      int unsigned mode;
      int unsigned stretch;
      int unsigned hold;
      rsp_stall = 1'b0;
      mode      = 0;
      stretch   = 0;
      hold      = 0;
      forever begin
         @(negedge clock);
         if (stretch == 0) begin
            mode    = $urandom_range(0, 2);
            stretch = $urandom_range(20, 300);
         end
         stretch--;
         case (mode)
            0: rsp_stall = 1'b0;
            1: rsp_stall = ($urandom_range(0, 2) == 0);
            default: begin
               if (hold == 0) begin
                  rsp_stall = !rsp_stall;
                  hold      = rsp_stall ? $urandom_range(1, 15) : $urandom_range(1, 10);
               end
               hold--;
            end
         endcase
      end
   end

   // Response monitor
   always @(posedge clock) begin : rsp_monitor
      list_response_type got;
      if (!reset && rsp_valid !== 1'b0 && rsp_stall == 1'b0) begin
         got.status = status_type'(rsp_status);
         got.slot   = rsp_slot_out;
         got.handle = rsp_handle_out;
         got.cost   = rsp_cost_out;
         got.fill   = rsp_fill;
         mirror.check_response(got);
      end
   end

   initial begin
      #TIMEOUT_NS;
      $display("== FAIL ==");
      $finish;
   end

   initial begin : stimulus
      int unsigned goal;
      int unsigned steps;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_type    = OP_APPEND;
      req_slot    = '0;
      req_handle  = '0;
      req_cost    = '0;
      burst_left  = $urandom_range(0, 40);
      random_sent = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty table misses
      send_request(OP_LOWEST, 8'd0, 16'h0000, 16'h0000);
      send_request(OP_READ, 8'd0, 16'h0000, 16'h0000);
      send_request(OP_DEL_AT, 8'd0, 16'h0000, 16'h0000);
      send_request(OP_DEL_KEY, 8'd0, 16'h0000, 16'h0000);
      send_request(OP_FIND, 8'd0, 16'h0000, 16'h0000);
      // unused request codes
      send_request(OP_RSVD6, 8'h5A, 16'hA5A5, 16'h5A5A);
      send_request(OP_RSVD7, 8'hFF, 16'hFFFF, 16'hFFFF);
      // field extremes, a tie for the lowest and a duplicate handle
      send_request(OP_APPEND, 8'd0, 16'hFFFF, 16'hFFFF);
      send_request(OP_APPEND, 8'hFF, 16'h0000, 16'h0000);
      send_request(OP_APPEND, 8'd0, 16'h1234, 16'h0000);
      send_request(OP_APPEND, 8'd0, 16'hFFFF, 16'h0005);
      send_request(OP_LOWEST, 8'd0, 16'h0000, 16'h0000);
      send_request(OP_FIND, 8'd0, 16'hFFFF, 16'h0000);
      send_request(OP_FIND, 8'd0, 16'h5555, 16'h0000);
      send_request(OP_READ, 8'd3, 16'h0000, 16'h0000);
      send_request(OP_READ, 8'd4, 16'h0000, 16'h0000);
      send_request(OP_READ, 8'hFF, 16'h0000, 16'h0000);
      send_request(OP_DEL_KEY, 8'd0, 16'hFFFF, 16'h0000);
      send_request(OP_FIND, 8'd0, 16'hFFFF, 16'h0000);
      send_request(OP_DEL_AT, 8'd2, 16'h0000, 16'h0000);
      send_request(OP_DEL_AT, 8'd0, 16'h0000, 16'h0000);
      send_request(OP_LOWEST, 8'd0, 16'h0000, 16'h0000);
      send_request(OP_DEL_KEY, 8'd0, 16'h1234, 16'h0000);
      send_request(OP_LOWEST, 8'd0, 16'h0000, 16'h0000);

      // Fill to capacity, then keep appending against a full table
      while (mirror.count < CAPACITY_DEF) send_random(CAPACITY_DEF);
      repeat (30) send_random(CAPACITY_DEF);

      // Phases towards random fill targets
      while (random_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 3))
            0:       goal = 0;
            1:       goal = $urandom_range(1, 16);
            2:       goal = $urandom_range(0, CAPACITY_DEF);
            default: goal = CAPACITY_DEF;
         endcase
         steps = $urandom_range(30, 200);
         for (int unsigned k = 0; k < steps && random_sent < RANDOM_ITEMS; k++)
            send_random(goal);
      end
      req_valid = 1'b0;

      // Drain, then watch for stray responses
      while (mirror.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mirror.failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
